>>> sv/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants for the bidirectional flow classifier.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int MAX_SESSIONS_DEF = 256;
  localparam int ADDR_W           = 32;
  localparam int PORT_W           = 16;
  localparam int SESS_IDX_W       = 8;

  // flow key, also the layout of one stored session entry
  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
  } flow_key_t;

  // lookup status riding along the chain with each key
  typedef struct packed {
    logic                  valid;
    logic                  found;     // matched or claimed an entry
    logic                  reversed;
    logic                  is_new;
    logic [SESS_IDX_W-1:0] idx;
  } flow_tag_t;

endpackage

>>> sv/bfc_cell.sv
// ----------------------------------------------------------------------------
// bfc_cell
// One session slot: holds an entry, checks the passing key against it in
// both directions, claims the slot for a new flow, and registers the word on.
// ----------------------------------------------------------------------------
module bfc_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [CNT_W-1:0]   cnt,
  input  bfc_pkg::flow_key_t key_in,
  input  bfc_pkg::flow_tag_t tag_in,
  output bfc_pkg::flow_key_t key_out,
  output bfc_pkg::flow_tag_t tag_out,
  output logic               claim
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
  localparam logic [bfc_pkg::SESS_IDX_W-1:0] MY_SIDX = bfc_pkg::SESS_IDX_W'(IDX);

  bfc_pkg::flow_key_t entry_r;
  bfc_pkg::flow_key_t key_r;
  bfc_pkg::flow_tag_t tag_r;
  bfc_pkg::flow_tag_t tag_nxt;

  logic live;
  logic fwd;
  logic rev;
  logic hit;
  logic take;

  assign live = tag_in.valid && !tag_in.found;
  assign fwd  = (entry_r == key_in);
  assign rev  = (entry_r.src_addr == key_in.dst_addr) &&
                (entry_r.dst_addr == key_in.src_addr) &&
                (entry_r.src_port == key_in.dst_port) &&
                (entry_r.dst_port == key_in.src_port);
  assign hit  = live && (cnt > MY_IDX) && (fwd || rev);
  assign take = live && (cnt == MY_IDX);   // first free slot
  assign claim = en && take;

  always_comb begin
    tag_nxt = tag_in;
    if (hit) begin
      tag_nxt.found    = 1'b1;
      tag_nxt.reversed = !fwd;   // same direction wins on symmetric flows
      tag_nxt.idx      = MY_SIDX;
    end else if (take) begin
      tag_nxt.found  = 1'b1;
      tag_nxt.is_new = 1'b1;
      tag_nxt.idx    = MY_SIDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_r <= key_in;
    end
    if (claim) begin
      entry_r <= key_in;
    end
  end

  assign key_out = key_r;
  assign tag_out = tag_r;

endmodule

>>> sv/bidirectional_flow_classifier_top.sv
// ----------------------------------------------------------------------------
// bidirectional_flow_classifier_top
// Session table lookup and insert for packet 4-tuples, as a chain of slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one packet 4-tuple per word.
//   Output channel (out_valid/out_ready): one result word per input word,
//   in input order: session index, reversed, is_new, table_full.
//   The session table is a row of MAX_SESSIONS slots. Each accepted word
//   walks the row one slot per cycle while the chain advances; a slot below
//   the fill count compares its entry in both directions, the first free
//   slot takes the flow if nothing matched on the way. A word leaving the
//   last slot unmatched reports table_full.
//   Path: each word is registered in every slot of the chain, and the
//   result word comes straight from the last slot's register. Throughput:
//   one word per cycle while the output is not stalled; a new entry is
//   visible to every later word because the words follow it in order.
//   Reset: fill count cleared, chain emptied; entries need no clearing since
//   only slots below the fill count are compared.
//   Stall: while out_valid is high and out_ready low the whole chain holds
//   and in_ready is low; nothing is dropped.
// ----------------------------------------------------------------------------
module bidirectional_flow_classifier_top #(
  parameter int MAX_SESSIONS = bfc_pkg::MAX_SESSIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bfc_pkg::ADDR_W-1:0]        in_src_addr,
  input  logic [bfc_pkg::ADDR_W-1:0]        in_dst_addr,
  input  logic [bfc_pkg::PORT_W-1:0]        in_src_port,
  input  logic [bfc_pkg::PORT_W-1:0]        in_dst_port,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bfc_pkg::SESS_IDX_W-1:0]    out_session_index,
  output logic                              out_reversed,
  output logic                              out_is_new,
  output logic                              out_table_full
);

  localparam int CNT_W = $clog2(MAX_SESSIONS + 1);

  // stage k holds the word entering slot k; stage MAX_SESSIONS is the output
  bfc_pkg::flow_key_t key_s [0:MAX_SESSIONS];
  bfc_pkg::flow_tag_t tag_s [0:MAX_SESSIONS];
  logic [MAX_SESSIONS-1:0] claim;

  logic             adv;       // chain advances this cycle
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign adv      = !tag_s[MAX_SESSIONS].valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    key_s[0].src_addr = in_src_addr;
    key_s[0].dst_addr = in_dst_addr;
    key_s[0].src_port = in_src_port;
    key_s[0].dst_port = in_dst_port;
    tag_s[0]          = '0;
    tag_s[0].valid    = in_valid;
  end

  genvar k;
  generate
    for (k = 0; k < MAX_SESSIONS; k++) begin : g_slot
      bfc_cell #(
        .IDX   (k),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .cnt     (count_r),
        .key_in  (key_s[k]),
        .tag_in  (tag_s[k]),
        .key_out (key_s[k+1]),
        .tag_out (tag_s[k+1]),
        .claim   (claim[k])
      );
    end
  endgenerate

  // at most one slot claims per cycle: only one word sits at the free slot
  assign count_nxt = count_r + CNT_W'(|claim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result word straight from the last stage register
  assign out_valid         = tag_s[MAX_SESSIONS].valid;
  assign out_session_index = tag_s[MAX_SESSIONS].found ? tag_s[MAX_SESSIONS].idx : '0;
  assign out_reversed      = tag_s[MAX_SESSIONS].found && tag_s[MAX_SESSIONS].reversed;
  assign out_is_new        = tag_s[MAX_SESSIONS].found && tag_s[MAX_SESSIONS].is_new;
  assign out_table_full    = !tag_s[MAX_SESSIONS].found;

endmodule

>>> sv/bfc_checker.sv
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks for the flow classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bfc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bfc_pkg::SESS_IDX_W-1:0] out_session_index,
  input logic                           out_reversed,
  input logic                           out_is_new,
  input logic                           out_table_full
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_session_index) &&
      $stable(out_reversed) && $stable(out_is_new) && $stable(out_table_full))
    else $error("result word changed while stalled");

  // full table gives a plain zero result
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_is_new && !out_reversed &&
      out_session_index == '0)
    else $error("table_full result carries other flags");

  // a new session is never reversed
  a_new_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_new |-> !out_reversed && !out_table_full)
    else $error("new session flagged reversed or full");

  // stalled output freezes the chain, so no input is taken
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // chain is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind bidirectional_flow_classifier_top bfc_checker u_bfc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_session_index (out_session_index),
  .out_reversed      (out_reversed),
  .out_is_new        (out_is_new),
  .out_table_full    (out_table_full)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Flow classifier testbench
// Drives packet 4-tuples into the session table with random idle and stall,
// predicts session index, direction, new-entry and table-full flags from a
// local copy of the table, and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_SESSIONS    = bfc_pkg::MAX_SESSIONS_DEF;
  // each result walks the whole slot chain before it comes out
  localparam int DRAIN_CYCLES   = TB_SESSIONS + 16;
  localparam int HOLDOFF_CYCLES = 600;
  // longest quiet stretch: a full chain walk plus the holdoff, with margin
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  // expected result of one lookup
  typedef struct packed {
    logic [bfc_pkg::SESS_IDX_W-1:0] session_index;
    logic                           reversed;
    logic                           is_new;
    logic                           table_full;
  } flow_verdict_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [bfc_pkg::ADDR_W-1:0]     in_src_addr = '0;
  logic [bfc_pkg::ADDR_W-1:0]     in_dst_addr = '0;
  logic [bfc_pkg::PORT_W-1:0]     in_src_port = '0;
  logic [bfc_pkg::PORT_W-1:0]     in_dst_port = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [bfc_pkg::SESS_IDX_W-1:0] out_session_index;
  logic                           out_reversed;
  logic                           out_is_new;
  logic                           out_table_full;

  // local copy of the session table, updated at each input accept
  bfc_pkg::flow_key_t session_copy [TB_SESSIONS];
  int unsigned        stored_sessions = 0;
  flow_verdict_t      pending_verdicts [$];

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int          holdoff_seq   = 0;  // bumped by the test to request a holdoff
  int          holdoff_seen  = 0;
  int          holdoff_left  = 0;
  int          fail_count    = 0;
  int          quiet_cycles  = 0;

  bidirectional_flow_classifier_top #(
    .MAX_SESSIONS (TB_SESSIONS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_src_addr       (in_src_addr),
    .in_dst_addr       (in_dst_addr),
    .in_src_port       (in_src_port),
    .in_dst_port       (in_dst_port),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_session_index (out_session_index),
    .out_reversed      (out_reversed),
    .out_is_new        (out_is_new),
    .out_table_full    (out_table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction: scan stored sessions in index order, first hit in either
  // direction wins, same direction preferred on a symmetric flow. A miss
  // appends the flow, or flags table_full once every slot is taken.
  // --------------------------------------------------------------------------
  function automatic flow_verdict_t classify_flow(input bfc_pkg::flow_key_t k);
    flow_verdict_t v;
    logic          same_dir;
    logic          swap_dir;
    v = '0;
    for (int i = 0; i < stored_sessions; i++) begin
      same_dir = (session_copy[i] == k);
      swap_dir = session_copy[i].src_addr == k.dst_addr &&
                 session_copy[i].dst_addr == k.src_addr &&
                 session_copy[i].src_port == k.dst_port &&
                 session_copy[i].dst_port == k.src_port;
      if (same_dir || swap_dir) begin
        v.session_index = bfc_pkg::SESS_IDX_W'(i);
        v.reversed      = !same_dir;
        return v;
      end
    end
    if (stored_sessions < TB_SESSIONS) begin
      session_copy[stored_sessions] = k;
      v.session_index = bfc_pkg::SESS_IDX_W'(stored_sessions);
      v.is_new        = 1'b1;
      stored_sessions++;
    end else begin
      v.table_full = 1'b1;
    end
    return v;
  endfunction

  function automatic bfc_pkg::flow_key_t make_flow(input logic [bfc_pkg::ADDR_W-1:0] sa,
                                                   input logic [bfc_pkg::ADDR_W-1:0] da,
                                                   input logic [bfc_pkg::PORT_W-1:0] sp,
                                                   input logic [bfc_pkg::PORT_W-1:0] dp);
    bfc_pkg::flow_key_t k;
    k.src_addr = sa;
    k.dst_addr = da;
    k.src_port = sp;
    k.dst_port = dp;
    return k;
  endfunction

  // the same flow seen from the other end
  function automatic bfc_pkg::flow_key_t swap_ends(input bfc_pkg::flow_key_t k);
    return make_flow(k.dst_addr, k.src_addr, k.dst_port, k.src_port);
  endfunction

  // never-seen flow; some are symmetric, some carry equal ports
  function automatic bfc_pkg::flow_key_t fresh_flow();
    bfc_pkg::flow_key_t k;
    int unsigned        roll;
    k = make_flow($urandom(), $urandom(), bfc_pkg::PORT_W'($urandom()),
                  bfc_pkg::PORT_W'($urandom()));
    roll = $urandom_range(9);
    if (roll == 0) begin
      k.dst_addr = k.src_addr;
      k.dst_port = k.src_port;
    end else if (roll == 1) begin
      k.dst_port = k.src_port;
    end
    return k;
  endfunction

  // traffic mix: mostly known sessions both ways, some near misses, some new
  function automatic bfc_pkg::flow_key_t pick_flow();
    bfc_pkg::flow_key_t k;
    int unsigned        roll;
    roll = $urandom_range(99);
    if (stored_sessions == 0 || roll >= 75) begin
      k = fresh_flow();
    end else begin
      k = session_copy[$urandom_range(stored_sessions - 1)];
      if (roll >= 60) begin
        // one bit off an existing flow
        k = bfc_pkg::flow_key_t'(k ^ (96'd1 << $urandom_range(95)));
      end else if (roll >= 35) begin
        k = swap_ends(k);
      end
    end
    return k;
  endfunction

  // one packet word; valid held with a stable payload until accepted
  task automatic send_flow(input bfc_pkg::flow_key_t k);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_src_addr <= k.src_addr;
    in_dst_addr <= k.dst_addr;
    in_src_port <= k.src_port;
    in_dst_port <= k.dst_port;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(classify_flow(k));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall by percentage; a holdoff request forces ready low
  // for a fixed count, counted here so the sender keeps running meanwhile.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      holdoff_left <= 0;
      holdoff_seen <= 0;
    end else if (holdoff_seq != holdoff_seen) begin
      holdoff_seen <= holdoff_seq;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready    <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // result check: every accepted word against the oldest prediction
  always @(posedge clk) begin : check_results
    flow_verdict_t want;
    flow_verdict_t got;
    if (rst_n && out_valid && out_ready) begin
      got.session_index = out_session_index;
      got.reversed      = out_reversed;
      got.is_new        = out_is_new;
      got.table_full    = out_table_full;
      if (pending_verdicts.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: result word with nothing pending: %s",
                   $realtime,
                   $sformatf("idx=%0d rev=%b new=%b full=%b",
                             got.session_index, got.reversed, got.is_new,
                             got.table_full));
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.session_index !== want.session_index ||
            got.reversed !== want.reversed ||
            got.is_new !== want.is_new ||
            got.table_full !== want.table_full) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: mismatch exp idx=%0d rev=%b new=%b full=%b, %s",
                     $realtime, want.session_index, want.reversed, want.is_new,
                     want.table_full,
                     $sformatf("got idx=%0d rev=%b new=%b full=%b",
                               got.session_index, got.reversed, got.is_new,
                               got.table_full));
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without a word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // all-zero and all-one fields, mixed, then repeats of the all-zero and all-one flows
  task automatic test_field_extremes();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_flow(make_flow('0, '0, '0, '0));
    send_flow(make_flow('1, '1, '1, '1));
    send_flow(make_flow('0, '1, '0, '1));
    send_flow(make_flow('1, '0, '1, '0));   // other end of the previous one
    send_flow(make_flow('0, '0, '0, '0));   // symmetric: same direction wins
    send_flow(make_flow('1, '1, '1, '1));
  endtask

  // forward, swapped, equal ports, symmetric and partial matches
  task automatic test_match_directions();
    logic [bfc_pkg::ADDR_W-1:0] host_a;
    logic [bfc_pkg::ADDR_W-1:0] host_b;
    host_a = 32'h0A00_0001;
    host_b = 32'hC0A8_0002;
    send_flow(make_flow(host_a, host_b, 16'd1234, 16'd80));
    send_flow(make_flow(host_a, host_b, 16'd1234, 16'd80));
    send_flow(make_flow(host_b, host_a, 16'd80, 16'd1234));
    send_flow(make_flow(host_a, host_b, 16'd443, 16'd443));
    send_flow(make_flow(host_b, host_a, 16'd443, 16'd443));
    send_flow(make_flow(host_b, host_a, 16'd80, 16'd1235));
    // addresses forward, ports swapped: no match either way
    send_flow(make_flow(host_a, host_b, 16'd80, 16'd1234));
    send_flow(make_flow(host_a, host_a, 16'd53, 16'd53));
    send_flow(make_flow(host_a, host_a, 16'd53, 16'd53));
    send_flow(make_flow(host_a, host_b, 16'd1235, 16'd80));
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int          n_words);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n_words) send_flow(pick_flow());
  endtask

  // fill every slot, overflow, then hits on first and last entries
  task automatic test_table_full();
    while (stored_sessions < TB_SESSIONS) send_flow(fresh_flow());
    repeat (8) send_flow(fresh_flow());
    send_flow(session_copy[0]);
    send_flow(swap_ends(session_copy[TB_SESSIONS - 1]));
    send_flow(session_copy[TB_SESSIONS - 1]);
    send_flow(swap_ends(session_copy[0]));
  endtask

  // receiver holds off long enough for the chain to back up into in_ready
  task automatic test_output_holdoff();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    holdoff_seq++;
    repeat (300) send_flow(pick_flow());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_match_directions();
    test_random_traffic(0, 0, 380);
    test_random_traffic(81, 0, 380);
    test_table_full();
    test_random_traffic(0, 81, 380);
    test_random_traffic(28, 28, 380);
    test_output_holdoff();

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // catch any stray word behind the last one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bfc_pkg.sv
sv/bfc_cell.sv
sv/bidirectional_flow_classifier_top.sv
sv/bfc_checker.sv
tb/sv/testbench.sv
